// ===== rtl/rmm_pkg.sv =====
package rmm_pkg;

	// channel count and round counter width
	localparam int CHANNELS    = 8;
	localparam int ROUND_BITS  = 32;

	// field widths
	localparam int CH_W        = 3;
	localparam int DATA_W      = 64;

	// derived sizes
	localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W      = DATA_W + ROUND_BITS;
	localparam int CNT_W       = $clog2(PROD_W + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	// stream word layout
	localparam int IN_BITS     = CH_W + DATA_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = CH_W + 3 * DATA_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

	// classified sample passed from the front end to the back end
	typedef struct packed {
		logic [CH_W-1:0]          ch;
		logic signed [DATA_W-1:0] sample;
		logic [ROUND_BITS-1:0]    n;
		logic                     first_round;
		logic                     in_range;
	} item_t;

endpackage

// ===== rtl/rmm_front.sv =====
module rmm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rmm_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                           s_tlast,
	input  logic                           full,
	output logic                           push,
	output rmm_pkg::item_t                 push_item
);
	import rmm_pkg::*;

	logic [ROUND_BITS-1:0] round_q;
	logic [CH_W-1:0]       ch;

	// accept whenever the queue has room
	assign s_tready = !full;
	assign push     = s_tvalid && !full;
	assign ch       = s_tdata[CH_W-1:0];

	// classify the word against the round it arrives in
	always_comb begin
		push_item.ch          = ch;
		push_item.sample      = $signed(s_tdata[CH_W +: DATA_W]);
		push_item.n           = round_q;
		push_item.first_round = (round_q <= ROUND_BITS'(1));
		push_item.in_range    = (32'(ch) < 32'(CHANNELS));
	end

	// advance the shared round number on the last word of a round, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= ROUND_BITS'(1);
		end else if (push && s_tlast && (round_q != {ROUND_BITS{1'b1}})) begin
			round_q <= round_q + ROUND_BITS'(1);
		end
	end

endmodule

// ===== rtl/rmm_queue.sv =====
module rmm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rmm_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output rmm_pkg::item_t head,
	output logic           empty
);
	import rmm_pkg::*;

	item_t           slot_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W:0]   count_q;

	assign full  = (count_q == (QP_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// store incoming words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QP_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QP_W+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/rmm_back.sv =====
module rmm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rmm_pkg::item_t                  head,
	input  logic                            empty,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rmm_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import rmm_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_PREP = 3'd1;
	localparam logic [2:0] B_MUL  = 3'd2;
	localparam logic [2:0] B_SUM  = 3'd3;
	localparam logic [2:0] B_DIV  = 3'd4;
	localparam logic [2:0] B_RND  = 3'd5;
	localparam logic [2:0] B_DONE = 3'd6;

	// per-channel stores
	logic signed [DATA_W-1:0] max_mem  [CHANNELS];
	logic signed [DATA_W-1:0] min_mem  [CHANNELS];
	logic signed [DATA_W-1:0] mean_mem [CHANNELS];

	logic [2:0]               state_q;
	logic [CNT_W-1:0]         cnt_q;
	item_t                    item_q;
	logic signed [DATA_W-1:0] cur_max_q;
	logic signed [DATA_W-1:0] cur_min_q;
	logic signed [DATA_W-1:0] cur_mean_q;
	logic [DATA_W-1:0]        mag_q;
	logic                     mean_neg_q;
	logic [ROUND_BITS-1:0]    mplr_q;
	logic [PROD_W-1:0]        acc_q;
	logic [PROD_W-1:0]        num_q;
	logic [ROUND_BITS-1:0]    rem_q;
	logic                     neg_q;
	logic signed [DATA_W-1:0] res_max_q;
	logic signed [DATA_W-1:0] res_min_q;
	logic signed [DATA_W-1:0] res_mean_q;
	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;

	logic                     hand_off;
	logic [IDX_W-1:0]         head_idx;
	logic [IDX_W-1:0]         item_idx;
	logic signed [PROD_W:0]   acc_s;
	logic signed [PROD_W:0]   num_s;
	logic [PROD_W-1:0]        num_mag;
	logic [ROUND_BITS:0]      rem_sh;
	logic                     rem_ge;
	logic [ROUND_BITS-1:0]    rem_next;
	logic                     round_up;
	logic [DATA_W-1:0]        quot;

	assign pop      = (state_q == B_IDLE) && !empty;
	assign hand_off = (state_q == B_DONE) && (!m_tvalid_q || m_tready);
	assign head_idx = IDX_W'(head.ch);
	assign item_idx = IDX_W'(item_q.ch);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// signed numerator and its magnitude
	always_comb begin
		acc_s = $signed({1'b0, acc_q});
		if (mean_neg_q) begin
			acc_s = -acc_s;
		end
		num_s   = acc_s + {{(PROD_W + 1 - DATA_W){item_q.sample[DATA_W-1]}}, item_q.sample};
		num_mag = num_s[PROD_W] ? PROD_W'(-num_s) : num_s[PROD_W-1:0];
	end

	// one restoring divide step
	always_comb begin
		rem_sh   = {rem_q, num_q[PROD_W-1]};
		rem_ge   = (rem_sh >= {1'b0, item_q.n});
		rem_next = rem_ge ? ROUND_BITS'(rem_sh - {1'b0, item_q.n}) : rem_sh[ROUND_BITS-1:0];
		round_up = ({rem_q, 1'b0} >= {1'b0, item_q.n});
		quot     = num_q[DATA_W-1:0] + DATA_W'(round_up);
	end

	// datapath: read stores, multiply, divide, round
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				item_q     <= head;
				cur_max_q  <= max_mem[head_idx];
				cur_min_q  <= min_mem[head_idx];
				cur_mean_q <= mean_mem[head_idx];
			end
			B_PREP: begin
				if (!item_q.in_range) begin
					res_max_q  <= '0;
					res_min_q  <= '0;
					res_mean_q <= '0;
				end else if (item_q.first_round) begin
					res_max_q  <= item_q.sample;
					res_min_q  <= item_q.sample;
					res_mean_q <= item_q.sample;
				end else begin
					res_max_q  <= (cur_max_q < item_q.sample) ? item_q.sample : cur_max_q;
					res_min_q  <= (item_q.sample < cur_min_q) ? item_q.sample : cur_min_q;
				end
				mag_q      <= cur_mean_q[DATA_W-1] ? DATA_W'(-cur_mean_q) : cur_mean_q;
				mean_neg_q <= cur_mean_q[DATA_W-1];
				mplr_q     <= item_q.n - ROUND_BITS'(1);
				acc_q      <= '0;
				cnt_q      <= CNT_W'(ROUND_BITS);
			end
			B_MUL: begin
				// shift-add, most significant multiplier bit first
				acc_q  <= {acc_q[PROD_W-2:0], 1'b0} + (mplr_q[ROUND_BITS-1] ? PROD_W'(mag_q) : '0);
				mplr_q <= {mplr_q[ROUND_BITS-2:0], 1'b0};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			B_SUM: begin
				num_q <= num_mag;
				neg_q <= num_s[PROD_W];
				rem_q <= '0;
				cnt_q <= CNT_W'(PROD_W);
			end
			B_DIV: begin
				num_q <= {num_q[PROD_W-2:0], rem_ge};
				rem_q <= rem_next;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			B_RND: begin
				res_mean_q <= neg_q ? $signed(-quot) : $signed(quot);
			end
			B_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// sequence the work on one word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						state_q <= B_PREP;
					end
				end
				B_PREP: begin
					if (!item_q.in_range || item_q.first_round) begin
						state_q <= B_DONE;
					end else begin
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= B_SUM;
					end
				end
				B_SUM: begin
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= B_RND;
					end
				end
				B_RND: begin
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (hand_off) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// write back the channel's statistics
	always_ff @(posedge clk) begin
		if (hand_off && item_q.in_range) begin
			max_mem[item_idx]  <= res_max_q;
			min_mem[item_idx]  <= res_min_q;
			mean_mem[item_idx] <= res_mean_q;
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (hand_off) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hand_off) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, res_mean_q, res_min_q, res_max_q, item_q.ch};
		end
	end

endmodule

// ===== rtl/running_min_max_mean.sv =====
// Per-channel running maximum, minimum and rounded mean over rounds of samples.
// Each input word carries a channel, a signed 64-bit sample and tlast marking
// the last sample of a round; tlast advances a shared, saturating round number
// n. Each input word gives exactly one result word with the channel's max, min
// and mean after that sample. During round one a channel's statistics are set
// to the sample; later the mean becomes round((mean*(n-1)+sample)/n), half away
// from zero. A channel must receive a sample in round one before its later
// results mean anything; the stores are not cleared at reset. Words queue in a
// two-deep buffer and are processed one at a time: a round-one or out-of-range
// word goes from PREP straight to DONE; any later word passes through the
// bit-serial shift-add multiplier and the restoring divider, each retiring
// one bit per cycle, and then a rounding state. The result word is registered
// as the back end leaves DONE, once the output register is free.
module running_min_max_mean (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// channel [2:0], sample [66:3], zero pad above
	input  logic [rmm_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// channel_out [2:0], maximum [66:3], minimum [130:67], mean [194:131], pad above
	output logic [rmm_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import rmm_pkg::*;

	logic  push;
	logic  full;
	logic  pop;
	logic  empty;
	item_t push_item;
	item_t head;

	rmm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	rmm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	rmm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// the back end never takes from an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	// an accepted word is waiting in the queue on the next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !empty)
		else $error("accepted word not queued");

	// a word classified as round one carries round number one
	a_first_round_n: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && head.first_round) |-> (head.n == ROUND_BITS'(1)))
		else $error("round-one word with wrong round number");

	// the round number in the queue is never zero
	a_round_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (head.n != '0))
		else $error("zero round number queued");

endmodule
